>>> rtl/json_string_escape_bounded_unit_macros.svh
// ============================================================================
// json_string_escape_bounded_unit_macros.svh
// Assertion macros shared by the escaper RTL.
// ============================================================================
`ifndef JSON_STRING_ESCAPE_BOUNDED_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPE_BOUNDED_UNIT_MACROS_SVH

// same-cycle implication
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jse_pkg.sv
// ============================================================================
// jse_pkg
// Types and constants of the bounded JSON string escaper.
// ============================================================================
package jse_pkg;

    localparam logic [7:0]  CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0]  CHAR_QUOTE   = 8'h22;
    localparam logic [7:0]  CHAR_U       = 8'h75;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CTRL_LIMIT   = 8'h20;
    localparam logic [7:0]  TERM_BYTE    = 8'h00;
    localparam logic [15:0] CAP_RESET    = 16'd64;

    localparam logic [2:0]  NEED_PLAIN   = 3'd1;
    localparam logic [2:0]  NEED_PAIR    = 3'd2;
    localparam logic [2:0]  NEED_CTRL    = 3'd6;

    typedef logic [2:0] step_t;
    localparam step_t STEP_FIRST = 3'd0;
    localparam step_t STEP_U     = 3'd1;
    localparam step_t STEP_Z0    = 3'd2;
    localparam step_t STEP_Z1    = 3'd3;
    localparam step_t STEP_HI    = 3'd4;
    localparam step_t STEP_LO    = 3'd5;

    typedef enum logic [1:0] {
        JOB_TERM,
        JOB_PLAIN,
        JOB_PAIR,
        JOB_CTRL
    } job_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_terminator;
        logic       was_truncated;
        logic       last_of_run;
    } res_item_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;
        logic       trunc;
    } job_t;

    typedef struct packed {
        logic count_zero;
        logic stopped;
    } front_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        ch = (nib < 4'd10) ? (CHAR_ZERO + {4'd0, nib}) : (8'h57 + {4'd0, nib});
        return ch;
    endfunction

endpackage

>>> rtl/json_string_escape_bounded_unit.sv
// ============================================================================
// json_string_escape_bounded_unit
// JSON string escaper with a bounded output budget and terminator.
// ============================================================================
//  channel   handshake        payload
//  input     push / full      in_item  (data_byte, string_end)
//  result    empty / pop      result   (out_byte, is_terminator, was_truncated, last_of_run)
//  config    cfg_we           cfg_data (out_capacity)
//
//  The front takes one item per cycle while the 4-entry job queue has room.
//  The back emits one result byte per cycle while pop is held: one byte for
//  a plain byte or terminator, two for a quote or backslash, six for a control
//  character. Sustained rate is set by the back's byte expansion.
//  Reset clears the count, the stop flag, the queue and sets capacity to 64.
//  A stalled pop holds the result register; the queue absorbs short stalls.
// ============================================================================
module json_string_escape_bounded_unit #(
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  jse_pkg::in_item_t  in_item,
    output logic               empty,
    input  logic               pop,
    output jse_pkg::res_item_t result,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data
);
    import jse_pkg::*;

    `include "json_string_escape_bounded_unit_macros.svh"

    logic        take;
    logic        job_push;
    job_t        job_in, job_out;
    logic        q_rd, q_valid, q_full;
    front_stat_t stat;

    assign full = q_full;
    assign take = push && !q_full;

    jse_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .take     (take),
        .item     (in_item),
        .job_push (job_push),
        .job      (job_in),
        .stat     (stat)
    );

    jse_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_push),
        .wr_job  (job_in),
        .rd      (q_rd),
        .rd_job  (job_out),
        .q_valid (q_valid),
        .q_full  (q_full)
    );

    jse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (job_out),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // end of string leaves the budget state clean
    `JSE_ASSERT_NEXT(a_end_clears, take && in_item.string_end, stat.count_zero && !stat.stopped, "end item did not clear state")
    // once stopped only a terminator may be queued
    `JSE_ASSERT_NOW(a_stopped_quiet, stat.stopped && job_push, job_in.kind == JOB_TERM, "job queued after stop")
    // terminator is a single zero byte closing its run
    `JSE_ASSERT_NOW(a_term_shape, !empty && result.is_terminator, result.last_of_run && result.out_byte == TERM_BYTE, "bad terminator")

endmodule

>>> rtl/jse_front.sv
// ============================================================================
// jse_front
// Takes input items, applies the output budget and queues escape jobs.
// ============================================================================
module jse_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_data,
    input  logic                 take,
    input  jse_pkg::in_item_t    item,
    output logic                 job_push,
    output jse_pkg::job_t        job,
    output jse_pkg::front_stat_t stat
);
    import jse_pkg::*;

    localparam int W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
    localparam logic [W-1:0] COUNT_MAX = W'({COUNT_BITS{1'b1}});

    logic [15:0]           cap_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  stopped_reg, stopped_next;

    logic [2:0]   need;
    job_kind_t    kind;
    logic [W-1:0] budget, budget_raw, total;
    logic         cap_zero, fits;

    always_comb
    begin
        if (item.data_byte == CHAR_QUOTE || item.data_byte == CHAR_BSLASH)
        begin
            kind = JOB_PAIR;
            need = NEED_PAIR;
        end
        else if (item.data_byte < CTRL_LIMIT)
        begin
            kind = JOB_CTRL;
            need = NEED_CTRL;
        end
        else
        begin
            kind = JOB_PLAIN;
            need = NEED_PLAIN;
        end
        cap_zero   = (cap_reg == 16'd0);
        budget_raw = W'(cap_reg) - W'(1);
        budget     = (budget_raw > COUNT_MAX) ? COUNT_MAX : budget_raw;
        total      = W'(count_reg) + W'(need);
        fits       = (total <= budget);

        count_next   = count_reg;
        stopped_next = stopped_reg;
        job_push     = 1'b0;
        job.kind     = item.string_end ? JOB_TERM : kind;
        job.data     = item.data_byte;
        job.trunc    = stopped_reg;
        if (take)
        begin
            if (item.string_end)
            begin
                count_next   = '0;
                stopped_next = 1'b0;
                job_push     = !cap_zero;
            end
            else if (!cap_zero && !stopped_reg)
            begin
                if (fits)
                begin
                    count_next = total[COUNT_BITS-1:0];
                    job_push   = 1'b1;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.stopped    = stopped_reg;

endmodule

>>> rtl/jse_fifo.sv
// ============================================================================
// jse_fifo
// Four-entry job queue between the front and back halves.
// ============================================================================
module jse_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  jse_pkg::job_t wr_job,
    input  logic          rd,
    output jse_pkg::job_t rd_job,
    output logic          q_valid,
    output logic          q_full
);
    import jse_pkg::*;

    job_t       slot_reg [4];
    logic [1:0] wptr_reg, rptr_reg;
    logic [2:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 2'd1;
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wr_job;
        end
    end

    assign rd_job  = slot_reg[rptr_reg];
    assign q_valid = (cnt_reg != 3'd0);
    assign q_full  = (cnt_reg == 3'd4);

endmodule

>>> rtl/jse_back.sv
// ============================================================================
// jse_back
// Expands queued jobs into escaped result bytes, one per cycle while pop keeps up.
// ============================================================================
module jse_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  jse_pkg::job_t       q_job,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output jse_pkg::res_item_t  result
);
    import jse_pkg::*;

    job_t      job_reg;
    logic      job_valid_reg, job_valid_next;
    step_t     step_reg, step_next;
    res_item_t res_reg, res_next;
    logic      res_valid_reg, res_valid_next;
    logic      adv, is_last;
    logic [7:0] byte_sel;

    always_comb
    begin
        byte_sel = job_reg.data;
        is_last  = 1'b1;
        unique case (job_reg.kind)
            JOB_TERM:
            begin
                byte_sel = TERM_BYTE;
            end
            JOB_PLAIN:
            begin
                byte_sel = job_reg.data;
            end
            JOB_PAIR:
            begin
                is_last  = (step_reg != STEP_FIRST);
                byte_sel = is_last ? job_reg.data : CHAR_BSLASH;
            end
            JOB_CTRL:
            begin
                is_last = (step_reg == STEP_LO);
                case (step_reg)
                    STEP_FIRST: byte_sel = CHAR_BSLASH;
                    STEP_U:     byte_sel = CHAR_U;
                    STEP_HI:    byte_sel = hex_char(job_reg.data[7:4]);
                    STEP_LO:    byte_sel = hex_char(job_reg.data[3:0]);
                    default:    byte_sel = CHAR_ZERO;
                endcase
            end
            default:
            begin
                byte_sel = job_reg.data;
            end
        endcase

        adv  = job_valid_reg && (!res_valid_reg || pop);
        q_rd = q_valid && (!job_valid_reg || (adv && is_last));

        job_valid_next = job_valid_reg;
        step_next      = step_reg;
        if (q_rd)
        begin
            job_valid_next = 1'b1;
            step_next      = STEP_FIRST;
        end
        else if (adv)
        begin
            job_valid_next = !is_last;
            step_next      = step_reg + 3'd1;
        end

        res_next                = res_reg;
        res_next.out_byte       = byte_sel;
        res_next.is_terminator  = (job_reg.kind == JOB_TERM);
        res_next.was_truncated  = (job_reg.kind == JOB_TERM) && job_reg.trunc;
        res_next.last_of_run    = is_last;
        if (adv)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            step_reg      <= STEP_FIRST;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            job_reg <= q_job;
        end
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the bounded JSON string escaper.
// ============================================================================
// Strings go in one byte per transfer on the push side. An in-bench model of
// the escaper keeps its own capacity, byte count and stop flag, and queues the
// escaped bytes and terminators that each accepted transfer should produce.
// Every result popped is checked field by field against the oldest queued
// entry. Directed tests cover the escape classes, the budget edges, zero
// capacity and a capacity change in the middle of a string. Random strings
// under random capacities follow. Both sides stall in random bursts, except in
// some random chunks and in the closing test, which runs back to back.
// ============================================================================
module tb_top;
    import jse_pkg::*;

    localparam int      COUNT_BITS   = 16;
    localparam int      CLK_HALF     = 6;
    localparam int      RESET_CYCLES = 8;
    localparam int      DRAIN_CYCLES = 24;
    localparam int      RANDOM_ITEMS = 80;
    localparam int      CHUNK_ITEMS  = 30;
    localparam longint  LIMIT_NS     = 5_000_000;
    localparam string   HEX_DIGITS   = "0123456789abcdef";

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        push     = 1'b0;
    logic        pop      = 1'b0;
    logic        cfg_we   = 1'b0;
    logic [15:0] cfg_data = '0;
    in_item_t    in_item  = '0;
    logic        full;
    logic        empty;
    res_item_t   result;

    // escaper model state
    logic [15:0]           cap_model     = CAP_RESET;
    logic [COUNT_BITS-1:0] emitted_count = '0;
    logic                  halted        = 1'b0;
    res_item_t             escaped_q[$];

    int mismatches = 0;
    bit bursts_on  = 1'b1;

    json_string_escape_bounded_unit #(
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("json_string_escape_bounded_unit regression: fail");
        $finish;
    end

    // Returns how many results the transfer produces and queues them.
    function automatic int predict_escape(input in_item_t it);
        logic [7:0] seq[6];
        logic [7:0] c;
        logic       trunc;
        longint     budget;
        int         n;
        res_item_t  r;
        c = it.data_byte;
        if (it.string_end)
        begin
            trunc         = halted;
            emitted_count = '0;
            halted        = 1'b0;
            if (cap_model == 16'd0)
                return 0;
            r = '{out_byte: TERM_BYTE, is_terminator: 1'b1,
                  was_truncated: trunc, last_of_run: 1'b1};
            escaped_q.push_back(r);
            return 1;
        end
        if (cap_model == 16'd0 || halted)
            return 0;
        if (c == CHAR_QUOTE || c == CHAR_BSLASH)
        begin
            seq[0] = CHAR_BSLASH;
            seq[1] = c;
            n = 2;
        end
        else if (c < CTRL_LIMIT)
        begin
            seq[0] = CHAR_BSLASH;
            seq[1] = CHAR_U;
            seq[2] = CHAR_ZERO;
            seq[3] = CHAR_ZERO;
            seq[4] = HEX_DIGITS[c[7:4]];
            seq[5] = HEX_DIGITS[c[3:0]];
            n = 6;
        end
        else
        begin
            seq[0] = c;
            n = 1;
        end
        budget = longint'(cap_model) - 1;
        if (budget > (longint'(1) << COUNT_BITS) - 1)
            budget = (longint'(1) << COUNT_BITS) - 1;
        if (longint'(emitted_count) + n > budget)
        begin
            halted = 1'b1;
            return 0;
        end
        emitted_count = COUNT_BITS'(longint'(emitted_count) + longint'(n));
        for (int k = 0; k < n; k++)
        begin
            r = '{out_byte: seq[k], is_terminator: 1'b0,
                  was_truncated: 1'b0, last_of_run: (k == n - 1)};
            escaped_q.push_back(r);
        end
        return n;
    endfunction

    function automatic logic [7:0] random_char();
        case ($urandom_range(0, 9))
            4:       return CHAR_QUOTE;
            5:       return CHAR_BSLASH;
            6, 7:    return 8'($urandom_range(0, 31));
            8:       return TERM_BYTE;
            9:       return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    function automatic logic [15:0] random_capacity();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'($urandom_range(2, 8));
            3:       return 16'($urandom_range(9, 40));
            4:       return CAP_RESET;
            5:       return 16'hFFFF;
            6:       return 16'($urandom_range(41, 65534));
            default: return 16'($urandom_range(10, 30));
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR %0t: %s got 0x%02h expected 0x%02h", $time, field, got, want);
        mismatches++;
    endtask

    // push stays high across back-to-back transfers; it drops for a gap or a drain
    task automatic send_item(input in_item_t it, output int produced);
        int gap;
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (full);
        produced = predict_escape(it);
    endtask

    task automatic send_char(input logic [7:0] b);
        int n;
        send_item('{data_byte: b, string_end: 1'b0}, n);
    endtask

    task automatic send_end(input logic [7:0] junk);
        int n;
        send_item('{data_byte: junk, string_end: 1'b1}, n);
    endtask

    // dropped characters give no result, so allow extra cycles past the queue
    task automatic wait_drained();
        push <= 1'b0;
        while (escaped_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cap_model  = value;
    endtask

    // Reset capacity 64 leaves 63 bytes: ten control escapes, a pair, a plain
    // byte fill it exactly, and the next byte stops the string.
    task automatic test_default_capacity();
        for (int i = 0; i < 10; i++)
            send_char(8'(i * 3));
        send_char(CHAR_QUOTE);
        send_char(8'h7E);
        send_char(8'h41);
        send_end(8'h00);
    endtask

    task automatic test_escape_classes();
        write_capacity(16'hFFFF);
        send_char(CHAR_QUOTE);
        send_char(CHAR_BSLASH);
        send_char(TERM_BYTE);
        send_char(8'h1F);
        send_char(8'h0A);
        send_char(CTRL_LIMIT);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(8'hFF);
        send_end(8'hFF);
        send_end(CHAR_BSLASH);
    endtask

    task automatic test_budget_limits();
        write_capacity(16'd1);
        send_char(8'h41);
        send_end(8'h00);
        write_capacity(16'd7);
        send_char(8'h1B);
        send_end(8'h00);
        // once stopped, a byte that would fit is still dropped
        write_capacity(16'd3);
        send_char(8'h05);
        send_char(8'h61);
        send_end(8'h00);
        write_capacity(16'd2);
        send_char(8'h62);
        send_char(CHAR_BSLASH);
        send_end(8'h00);
    endtask

    // an end transfer at zero capacity emits nothing but still clears the stop
    task automatic test_zero_capacity();
        write_capacity(16'd3);
        send_char(8'h61);
        send_char(8'h62);
        send_char(8'h63);
        write_capacity(16'd0);
        send_char(CHAR_QUOTE);
        send_end(8'h00);
        write_capacity(16'd3);
        send_end(8'h00);
    endtask

    task automatic test_capacity_change();
        write_capacity(16'd10);
        send_char(8'h61);
        send_char(8'h62);
        send_char(8'h63);
        write_capacity(16'd4);
        send_char(8'h64);
        send_end(8'h00);
        write_capacity(16'd2);
        send_char(8'h65);
        write_capacity(16'd100);
        send_char(8'h19);
        send_end(8'h00);
    endtask

    // Mostly complete strings; some lone ends and some strings left open.
    task automatic test_random_strings();
        in_item_t it;
        int total;
        int sent;
        int len;
        int n;
        bit with_end;
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            write_capacity(random_capacity());
            bursts_on = ($urandom_range(0, 3) != 0);
            sent = 0;
            while (sent < CHUNK_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        len      = 0;
                        with_end = 1'b1;
                    end
                    1:
                    begin
                        len      = $urandom_range(1, 5);
                        with_end = 1'b0;
                    end
                    default:
                    begin
                        len      = $urandom_range(0, 14);
                        with_end = 1'b1;
                    end
                endcase
                for (int k = 0; k <= len; k++)
                begin
                    if (k < len)
                        it = '{data_byte: random_char(), string_end: 1'b0};
                    else if (with_end)
                        it = '{data_byte: 8'($urandom), string_end: 1'b1};
                    else
                        break;
                    send_item(it, n);
                    sent++;
                    total++;
                end
            end
        end
    endtask

    task automatic test_back_to_back();
        bursts_on = 1'b0;
        write_capacity(CAP_RESET);
        for (int i = 0; i < 20; i++)
            send_char(random_char());
        send_end(8'h00);
    endtask

    // result side: random pop stalls
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (bursts_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        res_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (escaped_q.size() == 0)
                report_mismatch("unexpected transfer, out_byte", result.out_byte, 8'h00);
            else
            begin
                want = escaped_q.pop_front();
                if (result.out_byte !== want.out_byte)
                    report_mismatch("out_byte", result.out_byte, want.out_byte);
                if (result.is_terminator !== want.is_terminator)
                    report_mismatch("is_terminator", 8'(result.is_terminator),
                                    8'(want.is_terminator));
                if (result.was_truncated !== want.was_truncated)
                    report_mismatch("was_truncated", 8'(result.was_truncated),
                                    8'(want.was_truncated));
                if (result.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 8'(result.last_of_run),
                                    8'(want.last_of_run));
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_capacity();
        test_escape_classes();
        test_budget_limits();
        test_zero_capacity();
        test_capacity_change();
        test_random_strings();
        test_back_to_back();
        wait_drained();
        if (mismatches == 0)
            $display("json_string_escape_bounded_unit regression: pass");
        else
            $display("json_string_escape_bounded_unit regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_fifo.sv
rtl/jse_back.sv
rtl/json_string_escape_bounded_unit.sv
tb/sv/tb_top.sv
